[sv/id3p_pkg.sv]
// shared types, constants and helpers for the id3v2 tag and frame parser
package id3p_pkg;

  // text bytes streamed at most for a year frame
  localparam int unsigned YEAR_CHARS = 4;
  localparam logic [31:0] YEAR_LIMIT = 32'(YEAR_CHARS);

  localparam logic [27:0] MAX28 = 28'h0FFFFFFF;

  localparam logic [7:0] MAGIC_I = "I";
  localparam logic [7:0] MAGIC_D = "D";
  localparam logic [7:0] MAGIC_3 = "3";
  localparam logic [7:0] SYNCSAFE_MASK = 8'h7f;

  localparam logic [31:0] CODE_TITLE  = "TIT2";
  localparam logic [31:0] CODE_ARTIST = "TPE1";
  localparam logic [31:0] CODE_ALBUM  = "TALB";
  localparam logic [31:0] CODE_YEAR   = "TYER";

  // byte positions inside the tag header
  localparam logic [3:0] HB_MAGIC_I   = 4'd0;
  localparam logic [3:0] HB_MAGIC_D   = 4'd1;
  localparam logic [3:0] HB_MAGIC_3   = 4'd2;
  localparam logic [3:0] HB_VER_MAJOR = 4'd3;
  localparam logic [3:0] HB_VER_REV   = 4'd4;
  localparam logic [3:0] HB_SIZE0     = 4'd6;
  localparam logic [3:0] HB_LAST      = 4'd9;

  // byte positions inside a frame header
  localparam logic [3:0] FB_FIRST = 4'd0;
  localparam logic [3:0] FB_SIZE0 = 4'd4;
  localparam logic [3:0] FB_FLAGS = 4'd8;
  localparam logic [3:0] FB_LAST  = 4'd9;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_FRAME   = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_TAG     = 3'd0,
    KIND_FRAME   = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_NOT_ID3 = 3'd3,
    KIND_END     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    FLD_TITLE  = 3'd0,
    FLD_ARTIST = 3'd1,
    FLD_ALBUM  = 3'd2,
    FLD_YEAR   = 3'd3,
    FLD_OTHER  = 3'd4
  } field_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] version;
    logic [27:0] tag_len;
    logic [31:0] code;
    logic [31:0] frame_len;
    field_e      field;
    logic [7:0]  text;
    logic        last;
  } rec_t;

  function automatic field_e classify(input logic [31:0] code);
    field_e f;
    if (code == CODE_TITLE) f = FLD_TITLE;
    else if (code == CODE_ARTIST) f = FLD_ARTIST;
    else if (code == CODE_ALBUM) f = FLD_ALBUM;
    else if (code == CODE_YEAR) f = FLD_YEAR;
    else f = FLD_OTHER;
    return f;
  endfunction

endpackage

[sv/id3p_parse.sv]
// per-byte parse state and record formation
module id3p_parse import id3p_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       sof_i,
  output logic       rec_valid_o,
  output rec_t       rec_o
);

  phase_e      phase_q, phase_d, phase_c;
  logic [3:0]  hidx_q, hidx_d, hidx_c;
  logic [27:0] tsize_q, tsize_d, tsize_c;
  logic [27:0] bcnt_q, bcnt_d, bcnt_c;
  logic [15:0] ver_q, ver_d, ver_c;
  logic [31:0] fcode_q, fcode_d, fcode_c;
  logic [31:0] fsize_q, fsize_d, fsize_c;
  logic [31:0] pidx_q, pidx_d, pidx_c;
  field_e      field_q, field_d, field_c;

  logic [31:0] last_idx;
  logic [31:0] final_idx;
  logic [27:0] bcnt_inc;

  always_comb begin
    // start of file restarts the parser on this very byte
    if (sof_i) begin
      phase_c = PH_HEADER;
      hidx_c  = '0;
      tsize_c = '0;
      bcnt_c  = '0;
      ver_c   = '0;
      fcode_c = '0;
      fsize_c = '0;
      pidx_c  = '0;
      field_c = FLD_OTHER;
    end else begin
      phase_c = phase_q;
      hidx_c  = hidx_q;
      tsize_c = tsize_q;
      bcnt_c  = bcnt_q;
      ver_c   = ver_q;
      fcode_c = fcode_q;
      fsize_c = fsize_q;
      pidx_c  = pidx_q;
      field_c = field_q;
    end

    phase_d = phase_c;
    hidx_d  = hidx_c;
    tsize_d = tsize_c;
    bcnt_d  = bcnt_c;
    ver_d   = ver_c;
    fcode_d = fcode_c;
    fsize_d = fsize_c;
    pidx_d  = pidx_c;
    field_d = field_c;

    rec_valid_o = 1'b0;
    rec_o       = '0;

    bcnt_inc  = (bcnt_c != MAX28) ? bcnt_c + 28'd1 : bcnt_c;
    last_idx  = fsize_c - 32'd1;
    final_idx = (field_c == FLD_YEAR && last_idx > YEAR_LIMIT) ? YEAR_LIMIT : last_idx;

    case (phase_c)
      PH_HEADER: begin
        if ((hidx_c == HB_MAGIC_I && byte_i != MAGIC_I) ||
            (hidx_c == HB_MAGIC_D && byte_i != MAGIC_D) ||
            (hidx_c == HB_MAGIC_3 && byte_i != MAGIC_3)) begin
          rec_valid_o = 1'b1;
          rec_o.kind  = KIND_NOT_ID3;
          phase_d     = PH_DONE;
        end else begin
          if (hidx_c == HB_VER_MAJOR) ver_d = {byte_i, 8'h00};
          else if (hidx_c == HB_VER_REV) ver_d = {ver_c[15:8], byte_i};
          else if (hidx_c >= HB_SIZE0) begin
            tsize_d = {tsize_c[20:0], 7'(byte_i & SYNCSAFE_MASK)};
          end
          if (hidx_c >= HB_LAST) begin
            rec_valid_o   = 1'b1;
            rec_o.kind    = KIND_TAG;
            rec_o.version = ver_d;
            rec_o.tag_len = tsize_d;
            bcnt_d        = '0;
            hidx_d        = '0;
            phase_d       = PH_FRAME;
          end else begin
            hidx_d = hidx_c + 4'd1;
          end
        end
      end
      PH_FRAME: begin
        // tag size is only checked where a new frame header would begin
        if (hidx_c == FB_FIRST && bcnt_c >= tsize_c) begin
          rec_valid_o = 1'b1;
          rec_o.kind  = KIND_END;
          phase_d     = PH_DONE;
        end else begin
          bcnt_d = bcnt_inc;
          if (hidx_c < FB_SIZE0) fcode_d = {fcode_c[23:0], byte_i};
          else if (hidx_c < FB_FLAGS) fsize_d = {fsize_c[23:0], byte_i};
          if (hidx_c >= FB_LAST) begin
            field_d         = classify(fcode_d);
            rec_valid_o     = 1'b1;
            rec_o.kind      = KIND_FRAME;
            rec_o.code      = fcode_d;
            rec_o.frame_len = fsize_d;
            rec_o.field     = field_d;
            hidx_d          = '0;
            pidx_d          = '0;
            phase_d         = (fsize_d == '0) ? PH_FRAME : PH_PAYLOAD;
          end else begin
            hidx_d = hidx_c + 4'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        bcnt_d = bcnt_inc;
        // index 0 is the encoding byte
        if (pidx_c >= 32'd1 && field_c != FLD_OTHER && pidx_c <= final_idx) begin
          rec_valid_o = 1'b1;
          rec_o.kind  = KIND_PAYLOAD;
          rec_o.field = field_c;
          rec_o.text  = byte_i;
          rec_o.last  = (pidx_c == final_idx);
        end
        if (pidx_c >= last_idx) begin
          hidx_d  = '0;
          pidx_d  = '0;
          phase_d = PH_FRAME;
        end else begin
          pidx_d = pidx_c + 32'd1;
        end
      end
      default: begin
        // done: ignore bytes until the next start of file
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hidx_q  <= '0;
      tsize_q <= '0;
      bcnt_q  <= '0;
      ver_q   <= '0;
      fcode_q <= '0;
      fsize_q <= '0;
      pidx_q  <= '0;
      field_q <= FLD_OTHER;
    end else if (take_i) begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      tsize_q <= tsize_d;
      bcnt_q  <= bcnt_d;
      ver_q   <= ver_d;
      fcode_q <= fcode_d;
      fsize_q <= fsize_d;
      pidx_q  <= pidx_d;
      field_q <= field_d;
    end
  end

endmodule

[sv/id3p_skid.sv]
// output register with a skid entry so input keeps flowing under output stall
module id3p_skid import id3p_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t push_rec_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rec_t out_rec_o
);

  logic main_vld_q, main_vld_d;
  logic skid_vld_q, skid_vld_d;
  rec_t main_q, main_d;
  rec_t skid_q, skid_d;
  logic pop;

  assign pop = main_vld_q && !out_stall_i;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (!main_vld_q || pop) begin
      // push only happens with the skid entry empty
      if (skid_vld_q) begin
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        main_d     = push_rec_i;
        main_vld_d = push_i;
      end
    end else if (push_i) begin
      skid_d     = push_rec_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_rec_o   = main_q;

endmodule

[sv/id3v2_tag_frame_parser_top.sv]
// top level of the id3v2 tag and frame parser
// Takes one file byte per beat and sustains one byte per cycle unless stalled; a
// byte's record, if it makes one, is registered in the output register or skid
// entry. The per-byte parse step is a single combinational pass over the parse
// registers, and the output side is an output register plus one skid entry, so
// input stall only rises once the output is stalled with two records waiting.
// There are no memories and no clearing pass: reset leaves the parser waiting
// for a tag header, and a start-of-file byte restarts it on that same byte.
module id3v2_tag_frame_parser_top import id3p_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  record_kind_o,
  output logic [15:0] tag_version_o,
  output logic [27:0] tag_length_o,
  output logic [31:0] frame_code_o,
  output logic [31:0] frame_length_o,
  output logic [2:0]  field_tag_o,
  output logic [7:0]  text_byte_o,
  output logic        last_text_o
);

  logic take;
  logic rec_valid;
  logic full;
  rec_t rec;
  rec_t out_rec;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  id3p_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (data_byte_i),
    .sof_i       (start_of_file_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  id3p_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && rec_valid),
    .push_rec_i  (rec),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rec_o   (out_rec)
  );

  assign record_kind_o  = out_rec.kind;
  assign tag_version_o  = out_rec.version;
  assign tag_length_o   = out_rec.tag_len;
  assign frame_code_o   = out_rec.code;
  assign frame_length_o = out_rec.frame_len;
  assign field_tag_o    = out_rec.field;
  assign text_byte_o    = out_rec.text;
  assign last_text_o    = out_rec.last;

endmodule

[sv/id3p_checker.sv]
// port-level assertions for the id3v2 tag and frame parser, bound to the top level
module id3p_checker import id3p_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  record_kind_o,
  input logic [15:0] tag_version_o,
  input logic [27:0] tag_length_o,
  input logic [31:0] frame_code_o,
  input logic [31:0] frame_length_o,
  input logic [2:0]  field_tag_o,
  input logic [7:0]  text_byte_o,
  input logic        last_text_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(record_kind_o) &&
      $stable(text_byte_o) && $stable(frame_code_o))
    else $error("stalled output beat changed");

  // input only stalls while a record is waiting at the output
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output beat waiting");

  // text beats only carry a recognised field
  a_text_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_PAYLOAD |-> field_tag_o != FLD_OTHER &&
      frame_code_o == '0 && frame_length_o == '0)
    else $error("text beat with bad field or stray frame fields");

  // tag header beats leave frame and text fields at zero
  a_tag_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == KIND_TAG |-> frame_code_o == '0 &&
      field_tag_o == '0 && text_byte_o == '0 && !last_text_o)
    else $error("tag header beat with stray fields");

  // status beats carry nothing but their kind
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == KIND_END || record_kind_o == KIND_NOT_ID3) |->
      tag_version_o == '0 && tag_length_o == '0 && frame_length_o == '0 &&
      field_tag_o == '0 && !last_text_o)
    else $error("status beat with stray fields");

endmodule

bind id3v2_tag_frame_parser_top id3p_checker u_checker (.*);
